// File: rtl/scheduled_pressure_sampler_core_defines.svh
`ifndef SCHEDULED_PRESSURE_SAMPLER_CORE_DEFINES_SVH
`define SCHEDULED_PRESSURE_SAMPLER_CORE_DEFINES_SVH

// Same-cycle implication on the block clock, off during reset.
`define SPS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on the block clock, off during reset.
`define SPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sps_pkg;

  localparam int HISTORY_DEPTH_DEF = 64;
  localparam int DUE_DELAY_DEF     = 8;
  localparam int NCH               = 3;
  localparam int ALU_W             = 42;
  localparam int SLOT_W            = 6;

  localparam logic [1:0] CH_NONE   = 2'd3;
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] CH_LAST   = 2'd2;

  localparam logic [2:0] CFG_OFFSET_TOP     = 3'd0;
  localparam logic [2:0] CFG_GAIN_TOP       = 3'd1;
  localparam logic [2:0] CFG_OFFSET_BOTTOM  = 3'd2;
  localparam logic [2:0] CFG_GAIN_BOTTOM    = 3'd3;
  localparam logic [2:0] CFG_OFFSET_CHAMBER = 3'd4;
  localparam logic [2:0] CFG_GAIN_CHAMBER   = 3'd5;

  localparam logic signed [31:0] GAIN_RESET = 32'sd65536;
  localparam logic signed [31:0] SAT_MAX    = 32'sh7fff_ffff;
  localparam logic signed [31:0] SAT_MIN    = 32'sh8000_0000;

  typedef logic signed [ALU_W-1:0] alu_t;

  typedef enum logic [1:0] {
    MODE_SCHED,
    MODE_RESULT,
    MODE_READ,
    MODE_IDLE
  } mode_t;

  typedef enum logic [2:0] {
    ALU_PEND_AGE,
    ALU_SCAN_AGE,
    ALU_CAL,
    ALU_DIFF,
    ALU_UPD,
    ALU_WRAP
  } alu_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DUE,
    ST_SCAN,
    ST_START,
    ST_MUL,
    ST_CAL,
    ST_DIFF,
    ST_UPD,
    ST_WRAP,
    ST_RDADDR,
    ST_RDDATA,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [31:0]        now_ms;
    logic signed [15:0] period_top;
    logic signed [15:0] period_bottom;
    logic signed [15:0] period_chamber;
    logic signed [23:0] sample;
    logic [1:0]         read_channel;
    logic [5:0]         read_index;
  } req_t;

  typedef struct packed {
    logic [1:0]         started_channel;
    logic signed [31:0] pressure;
    logic [5:0]         history_slot;
    logic               result_valid;
    logic               conversion_due;
  } rsp_t;

  typedef struct packed {
    logic [2:0]  addr;
    logic [31:0] wdata;
  } cfg_t;

  typedef struct packed {
    logic     req_ready;
    alu_sel_t alu_sel;
    logic     due_en;
    logic     scan_en;
    logic     start_en;
    logic     mul_en;
    logic     cal_en;
    logic     diff_en;
    logic     upd_en;
    logic     wrap_en;
    logic     rdaddr_en;
    logic     rddata_en;
    logic     out_load;
  } ctrl_t;

  typedef struct packed {
    logic  req_valid;
    mode_t mode;
    logic  pend_any;
    logic  rd_ch_ok;
    logic  scan_last;
    logic  wrap_borrow;
    logic  out_free;
  } stat_t;

endpackage

`default_nettype wire

// File: rtl/sps_chan_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sps_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/sps_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/sps_alu.sv
`timescale 1ns / 1ps
`default_nettype none

// Shared add/subtract unit; the sequencer's age, calibration, filter and wrap steps go through it.
module sps_alu (
  input  wire sps_pkg::alu_t a,
  input  wire sps_pkg::alu_t b,
  input  wire logic          sub,
  output sps_pkg::alu_t      y,
  output logic               neg
);

  sps_pkg::alu_t b_op;

  assign b_op = sub ? ~b : b;
  assign y    = a + b_op + sps_pkg::alu_t'(sub);
  assign neg  = y[sps_pkg::ALU_W-1];

endmodule

`default_nettype wire

// File: rtl/sps_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sps_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire sps_pkg::stat_t stat,
  output sps_pkg::ctrl_t      ctrl
);

  sps_pkg::state_t state;
  sps_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sps_pkg::ST_IDLE: begin
        if (stat.req_valid) state_next = sps_pkg::ST_DUE;
      end
      sps_pkg::ST_DUE: begin
        unique case (stat.mode)
          sps_pkg::MODE_SCHED:  state_next = stat.pend_any ? sps_pkg::ST_DONE : sps_pkg::ST_SCAN;
          sps_pkg::MODE_RESULT: state_next = stat.pend_any ? sps_pkg::ST_MUL : sps_pkg::ST_DONE;
          sps_pkg::MODE_READ:   state_next = stat.rd_ch_ok ? sps_pkg::ST_WRAP : sps_pkg::ST_DONE;
          sps_pkg::MODE_IDLE:   state_next = sps_pkg::ST_DONE;
        endcase
      end
      sps_pkg::ST_SCAN: begin
        if (stat.scan_last) state_next = sps_pkg::ST_START;
      end
      sps_pkg::ST_START:  state_next = sps_pkg::ST_DONE;
      sps_pkg::ST_MUL:    state_next = sps_pkg::ST_CAL;
      sps_pkg::ST_CAL:    state_next = sps_pkg::ST_DIFF;
      sps_pkg::ST_DIFF:   state_next = sps_pkg::ST_UPD;
      sps_pkg::ST_UPD:    state_next = sps_pkg::ST_DONE;
      sps_pkg::ST_WRAP: begin
        // repeated subtract of the depth until the index falls below it
        if (stat.wrap_borrow) state_next = sps_pkg::ST_RDADDR;
      end
      sps_pkg::ST_RDADDR: state_next = sps_pkg::ST_RDDATA;
      sps_pkg::ST_RDDATA: state_next = sps_pkg::ST_DONE;
      sps_pkg::ST_DONE: begin
        if (stat.out_free) state_next = sps_pkg::ST_IDLE;
      end
      default: state_next = sps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl         = '0;
    ctrl.alu_sel = sps_pkg::ALU_PEND_AGE;
    unique case (state)
      sps_pkg::ST_IDLE:   ctrl.req_ready = 1'b1;
      sps_pkg::ST_DUE:    ctrl.due_en = 1'b1;
      sps_pkg::ST_SCAN: begin
        ctrl.scan_en = 1'b1;
        ctrl.alu_sel = sps_pkg::ALU_SCAN_AGE;
      end
      sps_pkg::ST_START:  ctrl.start_en = 1'b1;
      sps_pkg::ST_MUL:    ctrl.mul_en = 1'b1;
      sps_pkg::ST_CAL: begin
        ctrl.cal_en  = 1'b1;
        ctrl.alu_sel = sps_pkg::ALU_CAL;
      end
      sps_pkg::ST_DIFF: begin
        ctrl.diff_en = 1'b1;
        ctrl.alu_sel = sps_pkg::ALU_DIFF;
      end
      sps_pkg::ST_UPD: begin
        ctrl.upd_en  = 1'b1;
        ctrl.alu_sel = sps_pkg::ALU_UPD;
      end
      sps_pkg::ST_WRAP: begin
        ctrl.wrap_en = 1'b1;
        ctrl.alu_sel = sps_pkg::ALU_WRAP;
      end
      sps_pkg::ST_RDADDR: ctrl.rdaddr_en = 1'b1;
      sps_pkg::ST_RDDATA: ctrl.rddata_en = 1'b1;
      sps_pkg::ST_DONE:   ctrl.out_load = stat.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/scheduled_pressure_sampler_core.sv
// Items pass from the accepting edge to the output register through the sequencer; a read item
// repeats the wrap subtraction until its index falls below the depth. One shared 42-bit adder and a
// registered 24x32 multiplier are stepped by the sequencer, one item at a time.
// The next request is taken once the result sits in the output register, even while that
// result waits on rsp.ready.
// Reset: synchronous, active high; history needs no clearing pass (per-channel fill count).
`timescale 1ns / 1ps
`default_nettype none
`include "scheduled_pressure_sampler_core_defines.svh"

module scheduled_pressure_sampler_core #(
  parameter int HISTORY_DEPTH = sps_pkg::HISTORY_DEPTH_DEF,
  parameter int DUE_DELAY_MS  = sps_pkg::DUE_DELAY_DEF
) (
  input wire logic clk,
  input wire logic rst,
  sps_chan_if.sink   req,
  sps_chan_if.source rsp,
  sps_chan_if.sink   cfg
);

  localparam int IDX_W     = $clog2(HISTORY_DEPTH);
  localparam int CNT_W     = $clog2(HISTORY_DEPTH + 1);
  localparam int RI_W      = (IDX_W > sps_pkg::SLOT_W) ? IDX_W : sps_pkg::SLOT_W;
  localparam int RAM_DEPTH = 3 << IDX_W;
  localparam int AW        = IDX_W + 2;

  localparam logic [RI_W:0]  DEPTH_RI   = (RI_W + 1)'(HISTORY_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HISTORY_DEPTH - 1);
  localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(HISTORY_DEPTH);
  localparam logic [31:0]    DUE_DELAY  = 32'(DUE_DELAY_MS);

  sps_pkg::ctrl_t ctrl;
  sps_pkg::stat_t stat;

  // configuration
  logic signed [31:0] offset [sps_pkg::NCH];
  logic signed [31:0] gain   [sps_pkg::NCH];

  // block state
  logic [1:0]         pending;
  logic [31:0]        pend_start;
  logic [31:0]        last_start [sps_pkg::NCH];
  logic signed [31:0] filt       [sps_pkg::NCH];
  logic [IDX_W-1:0]   widx       [sps_pkg::NCH];
  logic [CNT_W-1:0]   fill       [sps_pkg::NCH];

  // item working registers
  sps_pkg::req_t      item;
  logic [1:0]         scan_i;
  logic               found;
  logic [1:0]         best;
  logic [31:0]        best_t;
  logic signed [55:0] prod;
  sps_pkg::alu_t      acc;
  logic [RI_W-1:0]    rd_idx;
  logic               hit;
  sps_pkg::rsp_t      res;
  sps_pkg::rsp_t      out_data;
  logic               out_valid;

  // shared unit
  sps_pkg::alu_t      alu_a;
  sps_pkg::alu_t      alu_b;
  logic               alu_sub;
  sps_pkg::alu_t      alu_y;
  logic               alu_neg;

  logic [1:0]         ch;
  logic signed [15:0] scan_per;
  logic               elig;
  logic signed [31:0] sat;
  logic [31:0]        ram_rdata;

  assign ch = pending - 2'd1;

  always_comb begin
    unique case (scan_i)
      2'd0:    scan_per = item.period_top;
      2'd1:    scan_per = item.period_bottom;
      default: scan_per = item.period_chamber;
    endcase
  end

  // saturate the calibrated sum held in acc
  always_comb begin
    if (acc[sps_pkg::ALU_W-1:31] == '0 || acc[sps_pkg::ALU_W-1:31] == '1) begin
      sat = acc[31:0];
    end else if (acc[sps_pkg::ALU_W-1]) begin
      sat = sps_pkg::SAT_MIN;
    end else begin
      sat = sps_pkg::SAT_MAX;
    end
  end

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (ctrl.alu_sel)
      sps_pkg::ALU_PEND_AGE: begin
        alu_a   = sps_pkg::alu_t'(item.now_ms);
        alu_b   = sps_pkg::alu_t'(pend_start);
        alu_sub = 1'b1;
      end
      sps_pkg::ALU_SCAN_AGE: begin
        alu_a   = sps_pkg::alu_t'(item.now_ms);
        alu_b   = sps_pkg::alu_t'(last_start[scan_i]);
        alu_sub = 1'b1;
      end
      sps_pkg::ALU_CAL: begin
        alu_a = sps_pkg::alu_t'(offset[ch]);
        alu_b = sps_pkg::alu_t'($signed(prod[55:16]));
      end
      sps_pkg::ALU_DIFF: begin
        alu_a   = sps_pkg::alu_t'(sat);
        alu_b   = sps_pkg::alu_t'(filt[ch]);
        alu_sub = 1'b1;
      end
      sps_pkg::ALU_UPD: begin
        alu_a = sps_pkg::alu_t'(filt[ch]);
        alu_b = acc >>> 2;
      end
      sps_pkg::ALU_WRAP: begin
        alu_a   = sps_pkg::alu_t'(rd_idx);
        alu_b   = sps_pkg::alu_t'(DEPTH_RI);
        alu_sub = 1'b1;
      end
      default: ;
    endcase
  end

  sps_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .y   (alu_y),
    .neg (alu_neg)
  );

  // start time must not lie ahead of now; age then fits 32 bits
  assign elig = !alu_neg && !scan_per[15] && (scan_per != '0) &&
                (alu_y[31:0] > {16'd0, scan_per}) &&
                (!found || (last_start[scan_i] < best_t));

  sps_ram #(
    .WIDTH (32),
    .DEPTH (RAM_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ctrl.upd_en),
    .waddr ({ch, widx[ch]}),
    .wdata (alu_y[31:0]),
    .raddr ({item.read_channel, rd_idx[IDX_W-1:0]}),
    .rdata (ram_rdata)
  );

  assign stat.req_valid   = req.valid;
  assign stat.mode        = sps_pkg::mode_t'(item.mode);
  assign stat.pend_any    = (pending != sps_pkg::PEND_NONE);
  assign stat.rd_ch_ok    = (item.read_channel != sps_pkg::CH_NONE);
  assign stat.scan_last   = (scan_i == sps_pkg::CH_LAST);
  assign stat.wrap_borrow = alu_neg;
  assign stat.out_free    = !out_valid || rsp.ready;

  sps_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  assign req.ready = ctrl.req_ready;
  assign cfg.ready = 1'b1;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < sps_pkg::NCH; i++) begin
        offset[i] <= '0;
        gain[i]   <= sps_pkg::GAIN_RESET;
      end
    end else if (cfg.valid) begin
      unique case (cfg.data.addr)
        sps_pkg::CFG_OFFSET_TOP:     offset[0] <= $signed(cfg.data.wdata);
        sps_pkg::CFG_GAIN_TOP:       gain[0]   <= $signed(cfg.data.wdata);
        sps_pkg::CFG_OFFSET_BOTTOM:  offset[1] <= $signed(cfg.data.wdata);
        sps_pkg::CFG_GAIN_BOTTOM:    gain[1]   <= $signed(cfg.data.wdata);
        sps_pkg::CFG_OFFSET_CHAMBER: offset[2] <= $signed(cfg.data.wdata);
        sps_pkg::CFG_GAIN_CHAMBER:   gain[2]   <= $signed(cfg.data.wdata);
        default: ;
      endcase
    end
  end

  // block state
  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= sps_pkg::PEND_NONE;
      pend_start <= '0;
      for (int i = 0; i < sps_pkg::NCH; i++) begin
        last_start[i] <= '0;
        filt[i]       <= '0;
        widx[i]       <= '0;
        fill[i]       <= '0;
      end
    end else begin
      if (ctrl.start_en && found) begin
        last_start[best] <= item.now_ms;
        pend_start       <= item.now_ms;
        pending          <= best + 2'd1;
      end
      if (ctrl.upd_en) begin
        filt[ch] <= alu_y[31:0];
        widx[ch] <= (widx[ch] == IDX_LAST) ? '0 : widx[ch] + 1'b1;
        if (fill[ch] != FILL_MAX) fill[ch] <= fill[ch] + 1'b1;
        pending <= sps_pkg::PEND_NONE;
      end
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item   <= req.data;
      rd_idx <= RI_W'(req.data.read_index);
    end
    if (ctrl.due_en) begin
      scan_i                  <= '0;
      found                   <= 1'b0;
      res.started_channel     <= sps_pkg::CH_NONE;
      res.pressure            <= '0;
      res.history_slot        <= '0;
      res.result_valid        <= 1'b0;
      res.conversion_due      <= (pending != sps_pkg::PEND_NONE) && (alu_y[31:0] > DUE_DELAY);
    end
    if (ctrl.scan_en) begin
      if (elig) begin
        found  <= 1'b1;
        best   <= scan_i;
        best_t <= last_start[scan_i];
      end
      scan_i <= scan_i + 2'd1;
    end
    if (ctrl.start_en && found) begin
      res.started_channel <= best;
    end
    if (ctrl.mul_en) begin
      prod <= $signed(item.sample) * gain[ch];
    end
    if (ctrl.cal_en || ctrl.diff_en) begin
      acc <= alu_y;
    end
    if (ctrl.upd_en) begin
      res.pressure     <= alu_y[31:0];
      res.history_slot <= sps_pkg::SLOT_W'(widx[ch]);
      res.result_valid <= 1'b1;
    end
    if (ctrl.wrap_en && !alu_neg) begin
      rd_idx <= alu_y[RI_W-1:0];
    end
    if (ctrl.rdaddr_en) begin
      // entries at or beyond the fill count were never written and read as zero
      hit <= ({1'b0, rd_idx} < (RI_W + 1)'(fill[item.read_channel]));
    end
    if (ctrl.rddata_en) begin
      res.pressure     <= hit ? $signed(ram_rdata) : '0;
      res.history_slot <= sps_pkg::SLOT_W'(rd_idx);
      res.result_valid <= 1'b1;
    end
    if (ctrl.out_load) begin
      out_data <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  `SPS_ASSERT_NEXT(a_upd_clears_pending, ctrl.upd_en, pending == sps_pkg::PEND_NONE, "pending mark kept after result")
  `SPS_ASSERT_IMPL(a_read_index_wrapped, ctrl.rdaddr_en, {1'b0, rd_idx} < DEPTH_RI, "history read index not reduced")
  `SPS_ASSERT_IMPL(a_start_sets_pending, ctrl.out_load && (res.started_channel != sps_pkg::CH_NONE), pending != sps_pkg::PEND_NONE, "started channel without pending mark")

endmodule

`default_nettype wire
